// ----- sv/min_max_feature_scaler_defines.svh -----
// ----------------------------------------------------------------------------
// Min-max feature scaler: assertion macros
// Concurrent property shorthands sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_FEATURE_SCALER_DEFINES_SVH
`define MIN_MAX_FEATURE_SCALER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MMFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MMFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Min-max feature scaler package
// Sizes, status codes and register indexes shared by the RTL and its checker.
// ----------------------------------------------------------------------------
package mmfs_pkg;

  localparam int FEATURES = 64;
  localparam int ADDR_W   = $clog2(FEATURES);
  localparam int FEAT_W   = 6;
  localparam int DATA_W   = 32;
  localparam int NF_W     = 7;
  localparam int CFG_AW   = 3;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SATURATED = 3'd1;
  localparam status_t ST_RANGE_LOW = 3'd2;
  localparam status_t ST_BAD_INDEX = 3'd3;
  localparam status_t ST_UNFITTED  = 3'd4;

  localparam logic MODE_FIT       = 1'b0;
  localparam logic MODE_TRANSFORM = 1'b1;

  // register index is paddr[2]
  localparam logic REG_NUM_FEATURES = 1'b0;
  localparam logic REG_MIN_RANGE    = 1'b1;

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// ----- sv/min_max_feature_scaler.sv -----
// ----------------------------------------------------------------------------
// Min-max feature scaler: per-feature (value - min) / (max - min), Q16.16 in.
// Transform: S_RD, S_CHK, S_DIV (the divider), S_SGN, S_FIN; next input back in S_IDLE.
// Fit, error and early-saturated transactions go from S_CHK straight to S_FIN.
// Sync active-low reset clears fitted flags and config (64 features, floor 1).
// ----------------------------------------------------------------------------
module min_max_feature_scaler import mmfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic                     in_first_row,
  input  logic [FEAT_W-1:0]        in_feature,
  input  logic signed [DATA_W-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_scaled,
  output logic [2:0]               out_status,
  output logic [FEAT_W-1:0]        out_feature_echo,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_DIV, S_SGN, S_FIN} state_t;

  state_t state_r;

  // configuration
  logic [NF_W-1:0]   num_features_r;
  logic [DATA_W-1:0] min_range_r;

  // captured transaction
  logic              mode_r;
  logic              first_r;
  logic [FEAT_W-1:0] feat_r;
  logic [DATA_W-1:0] value_r;
  logic              idx_ok_r;
  logic              fitted_hit_r;

  // state stores: {max, min} per feature, plus fitted flags
  logic [2*DATA_W-1:0] mm_mem [FEATURES];
  logic [2*DATA_W-1:0] mem_rd_r;
  logic                fitted_r [FEATURES];

  // datapath
  logic [DATA_W-1:0] range_r;
  logic [DATA_W:0]   num_r;
  logic              neg_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] res_scaled_r;
  status_t           res_status_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_scaled_r;
  status_t           out_status_r;
  logic [FEAT_W-1:0] out_feature_r;

  logic              in_acc;
  logic              cfg_wr;
  logic              idx_ok_nxt;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] feat_addr;

  logic signed [DATA_W-1:0] cur_min, cur_max, val_s;
  logic signed [DATA_W-1:0] fit_min, fit_max, sel_min, sel_max;
  logic              restart;
  logic              fit_wr;
  logic [DATA_W-1:0] range_nxt;
  logic [DATA_W:0]   num_nxt;

  logic              below_floor;
  logic [DATA_W:0]   mag;
  logic              quot_ovf;

  logic [DATA_W:0]   div_t;
  logic              div_ge;
  logic [DATA_W:0]   div_diff;
  logic [DATA_W-1:0] rem_nxt;
  logic [DATA_W-1:0] dq_nxt;

  logic              out_free;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_scaled       = out_scaled_r;
  assign out_status       = out_status_r;
  assign out_feature_echo = out_feature_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_addr   = in_feature[ADDR_W-1:0];
  assign feat_addr = feat_r[ADDR_W-1:0];
  assign idx_ok_nxt = ({1'b0, in_feature} < num_features_r) && (int'(in_feature) < FEATURES);

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_features_r <= NF_W'(FEATURES);
      min_range_r    <= 32'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_FEATURES: num_features_r <= pwdata[NF_W-1:0];
        REG_MIN_RANGE:    min_range_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_FEATURES: prdata = {{(32-NF_W){1'b0}}, num_features_r};
      REG_MIN_RANGE:    prdata = min_range_r;
      default:          prdata = '0;
    endcase
  end

  // ---------------- read stage: fit update ----------------
  assign cur_min = $signed(mem_rd_r[DATA_W-1:0]);
  assign cur_max = $signed(mem_rd_r[2*DATA_W-1:DATA_W]);
  assign val_s   = $signed(value_r);
  assign restart = first_r || !fitted_r[feat_addr];
  assign fit_min = (restart || (val_s < cur_min)) ? val_s : cur_min;
  assign fit_max = (restart || (val_s > cur_max)) ? val_s : cur_max;
  assign sel_min = (mode_r == MODE_FIT) ? fit_min : cur_min;
  assign sel_max = (mode_r == MODE_FIT) ? fit_max : cur_max;
  // max >= min holds for fitted features, so the 32-bit difference is the unsigned range
  assign range_nxt = DATA_W'(sel_max - sel_min);
  assign num_nxt   = {val_s[DATA_W-1], val_s} - {cur_min[DATA_W-1], cur_min};
  assign fit_wr    = (state_r == S_RD) && (mode_r == MODE_FIT) && idx_ok_r;

  // write-back in S_RD; next read can only be issued from S_IDLE, so no overlap
  always_ff @(posedge clk) begin
    if (fit_wr) begin
      mm_mem[feat_addr] <= {fit_max, fit_min};
    end
    if (in_acc) begin
      mem_rd_r <= mm_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEATURES; i++) fitted_r[i] <= 1'b0;
    end else if (fit_wr) begin
      fitted_r[feat_addr] <= 1'b1;
    end
  end

  // ---------------- check stage ----------------
  assign below_floor = (range_r == '0) || (range_r < min_range_r);
  assign mag         = num_r[DATA_W] ? ((DATA_W+1)'(0) - num_r) : num_r;
  // quotient >= 2^32 when the top 17 dividend bits already reach the divisor
  assign quot_ovf    = (DATA_W'(mag[DATA_W:16]) >= range_r);

  // ---------------- restoring divider step ----------------
  assign div_t    = {rem_r, dq_r[DATA_W-1]};
  assign div_ge   = (div_t >= {1'b0, range_r});
  assign div_diff = div_t - {1'b0, range_r};
  assign rem_nxt  = div_ge ? div_diff[DATA_W-1:0] : div_t[DATA_W-1:0];
  assign dq_nxt   = {dq_r[DATA_W-2:0], div_ge};

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mode_r   <= in_mode;
            first_r  <= in_first_row;
            feat_r   <= in_feature;
            value_r  <= in_value;
            idx_ok_r <= idx_ok_nxt;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          range_r      <= range_nxt;
          num_r        <= num_nxt;
          fitted_hit_r <= fitted_r[feat_addr];
          state_r      <= S_CHK;
        end
        S_CHK: begin
          if (!idx_ok_r) begin
            res_scaled_r <= '0;
            res_status_r <= ST_BAD_INDEX;
            state_r      <= S_FIN;
          end else if (mode_r == MODE_FIT) begin
            res_scaled_r <= '0;
            res_status_r <= below_floor ? ST_RANGE_LOW : ST_OK;
            state_r      <= S_FIN;
          end else if (!fitted_hit_r) begin
            res_scaled_r <= '0;
            res_status_r <= ST_UNFITTED;
            state_r      <= S_FIN;
          end else if (below_floor) begin
            res_scaled_r <= '0;
            res_status_r <= ST_RANGE_LOW;
            state_r      <= S_FIN;
          end else if (quot_ovf) begin
            res_status_r <= ST_SATURATED;
            res_scaled_r <= num_r[DATA_W] ? SAT_NEG : SAT_POS;
            state_r      <= S_FIN;
          end else begin
            // dividend is mag << 16; its upper part seeds the remainder
            rem_r   <= DATA_W'(mag[DATA_W:16]);
            dq_r    <= {mag[15:0], 16'd0};
            neg_r   <= num_r[DATA_W];
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          dq_r  <= dq_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_SGN;
          end
        end
        S_SGN: begin
          if (!neg_r) begin
            if (dq_r[DATA_W-1]) begin
              res_scaled_r <= SAT_POS;
              res_status_r <= ST_SATURATED;
            end else begin
              res_scaled_r <= dq_r;
              res_status_r <= ST_OK;
            end
          end else if (dq_r > SAT_NEG) begin
            res_scaled_r <= SAT_NEG;
            res_status_r <= ST_SATURATED;
          end else begin
            res_scaled_r <= DATA_W'(0) - dq_r;
            res_status_r <= ST_OK;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_scaled_r  <= res_scaled_r;
            out_status_r  <= res_status_r;
            out_feature_r <= feat_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/mmfs_checker.sv -----
// ----------------------------------------------------------------------------
// Min-max feature scaler port checker
// Watches the top-level ports for handshake and result-encoding slips.
// ----------------------------------------------------------------------------
`include "min_max_feature_scaler_defines.svh"

module mmfs_checker import mmfs_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_scaled,
  input logic [2:0]               out_status,
  input logic [FEAT_W-1:0]        out_feature_echo
);

  logic [DATA_W+FEAT_W+2:0] out_payload;
  logic                     out_wait;
  logic                     err_code;
  logic                     at_bound;

  assign out_payload = {out_scaled, out_status, out_feature_echo};
  assign out_wait    = out_valid && out_stall;
  assign err_code    = (out_status == ST_RANGE_LOW) || (out_status == ST_BAD_INDEX) ||
                       (out_status == ST_UNFITTED);
  assign at_bound    = (out_scaled == SAT_POS) || (out_scaled == SAT_NEG);

  `MMFS_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_payload), "stall not held")

  // one transaction at a time: the input side closes right after an accept
  `MMFS_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "input accepted while busy")

  `MMFS_ASSERT_SAME(a_err_zero, out_valid && err_code, out_scaled == '0, "error result not zero")

  `MMFS_ASSERT_SAME(a_sat_bound, out_valid && out_status == ST_SATURATED, at_bound, "sat off bound")

endmodule

bind min_max_feature_scaler mmfs_checker u_mmfs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_scaled       (out_scaled),
  .out_status       (out_status),
  .out_feature_echo (out_feature_echo)
);

// ----- test/min_max_feature_scaler_tb.sv -----
// ----------------------------------------------------------------------------
// Min-max feature scaler testbench
// Sends fit and transform transactions through the valid/stall input channel.
// Each accepted result is checked against an in-bench fixed-point scaler, or a typed table row.
// Register settings change between table rows and phases over the APB-style port.
// A short directed table runs first, followed by random phases with random
// idling on both sides except in phase 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_feature_scaler_tb;
  import mmfs_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 232;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] scaled;
    status_t                  status;
    logic [FEAT_W-1:0]        feat;
  } scaler_result_t;

  typedef struct packed {
    logic [NF_W-1:0]   nf;
    logic [31:0]       floor;
    logic              mode;
    logic              first;
    logic [FEAT_W-1:0] feat;
    logic [DATA_W-1:0] value;
    logic              typed;
    logic [DATA_W-1:0] scaled;
    status_t           status;
  } probe_row_t;

  localparam int PROBES = 24;

  // typed rows carry the result read straight off the behaviour;
  // the rest go through the scaler model
  probe_row_t probes [PROBES] = '{
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b0, 6'd0,  32'h0000_0000, 1'b1, 32'd0, ST_UNFITTED},
    '{7'd64, 32'd1, MODE_FIT,       1'b1, 6'd0,  32'h0000_0000, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b0, 6'd0,  32'h0000_0000, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd64, 32'd1, MODE_FIT,       1'b0, 6'd0,  32'h0001_0000, 1'b1, 32'd0, ST_OK},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b0, 6'd0,  32'h0000_8000, 1'b0, 32'd0, ST_OK},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b1, 6'd0,  32'hFFFF_8000, 1'b0, 32'd0, ST_OK},
    '{7'd64, 32'd1, MODE_FIT,       1'b1, 6'd63, 32'h8000_0000, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd64, 32'd1, MODE_FIT,       1'b0, 6'd63, 32'h7FFF_FFFF, 1'b1, 32'd0, ST_OK},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b0, 6'd63, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000, ST_OK},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b0, 6'd63, 32'h8000_0000, 1'b1, 32'd0, ST_OK},
    '{7'd64, 32'd1, MODE_FIT,       1'b1, 6'd1,  32'h0000_0000, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd64, 32'd1, MODE_FIT,       1'b0, 6'd1,  32'h0000_0001, 1'b1, 32'd0, ST_OK},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b0, 6'd1,  32'h7FFF_FFFF, 1'b1, SAT_POS, ST_SATURATED},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b0, 6'd1,  32'h8000_0000, 1'b1, SAT_NEG, ST_SATURATED},
    '{7'd64, 32'd1, MODE_FIT,       1'b1, 6'd0,  32'h1234_5678, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd64, 32'd1, MODE_TRANSFORM, 1'b1, 6'd2,  32'h0000_0000, 1'b1, 32'd0, ST_UNFITTED},
    '{7'd64, 32'd1, MODE_FIT,       1'b0, 6'd3,  32'h0000_0005, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd48, 32'd0, MODE_FIT,       1'b1, 6'd48, 32'h0000_0000, 1'b1, 32'd0, ST_BAD_INDEX},
    '{7'd48, 32'd0, MODE_TRANSFORM, 1'b0, 6'd63, 32'h0000_0000, 1'b1, 32'd0, ST_BAD_INDEX},
    '{7'd48, 32'd0, MODE_TRANSFORM, 1'b0, 6'd3,  32'h0000_0005, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd48, 32'd0, MODE_TRANSFORM, 1'b0, 6'd47, 32'h0000_0000, 1'b1, 32'd0, ST_UNFITTED},
    '{7'd64, 32'h0002_0000, MODE_FIT, 1'b0, 6'd1, 32'h0001_0000, 1'b1, 32'd0, ST_RANGE_LOW},
    '{7'd64, 32'h0002_0000, MODE_TRANSFORM, 1'b0, 6'd1, 32'h0000_8000, 1'b1, 32'd0,
      ST_RANGE_LOW},
    '{7'd64, 32'h0002_0000, MODE_TRANSFORM, 1'b0, 6'd63, 32'h0000_0000, 1'b0, 32'd0, ST_OK}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_mode;
  logic                     in_first_row;
  logic [FEAT_W-1:0]        in_feature;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_scaled;
  logic [2:0]               out_status;
  logic [FEAT_W-1:0]        out_feature_echo;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_AW-1:0]        paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  // scaler model state
  logic [NF_W-1:0]          nf_cfg;
  logic [31:0]              floor_cfg;
  logic signed [DATA_W-1:0] lo_store [FEATURES];
  logic signed [DATA_W-1:0] hi_store [FEATURES];
  bit                       fitted [FEATURES];

  scaler_result_t results_due [$];
  int  mismatch_count = 0;
  int  cfg_mismatch_count = 0;
  int  idle_cycles = 0;
  bit  quiet;

  min_max_feature_scaler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_first_row     (in_first_row),
    .in_feature       (in_feature),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scaled       (out_scaled),
    .out_status       (out_status),
    .out_feature_echo (out_feature_echo),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // zero span is always degenerate, whatever the floor
  function automatic bit span_too_small(input logic [FEAT_W-1:0] feat);
    longint span;
    span = longint'(hi_store[feat]) - longint'(lo_store[feat]);
    return (span == 0) || (span < longint'(floor_cfg));
  endfunction

  function automatic scaler_result_t scale_sample(input logic mode, input logic first,
                                                  input logic [FEAT_W-1:0] feat,
                                                  input logic signed [DATA_W-1:0] val);
    scaler_result_t res;
    longint         span;
    longint         num;
    bit [63:0]      mag;
    bit [63:0]      quo;
    res.scaled = '0;
    res.status = ST_OK;
    res.feat   = feat;
    if (feat >= nf_cfg) begin
      res.status = ST_BAD_INDEX;
    end else if (mode == MODE_FIT) begin
      if (first || !fitted[feat]) begin
        lo_store[feat] = val;
        hi_store[feat] = val;
        fitted[feat]   = 1'b1;
      end else begin
        if (val < lo_store[feat]) lo_store[feat] = val;
        if (val > hi_store[feat]) hi_store[feat] = val;
      end
      if (span_too_small(feat)) res.status = ST_RANGE_LOW;
    end else if (!fitted[feat]) begin
      res.status = ST_UNFITTED;
    end else if (span_too_small(feat)) begin
      res.status = ST_RANGE_LOW;
    end else begin
      span = longint'(hi_store[feat]) - longint'(lo_store[feat]);
      num  = longint'(val) - longint'(lo_store[feat]);
      mag  = (num < 0) ? -num : num;
      quo  = (mag << 16) / span;
      if (num >= 0 && quo > 64'h7FFF_FFFF) begin
        res.scaled = SAT_POS;
        res.status = ST_SATURATED;
      end else if (num < 0 && quo > 64'h8000_0000) begin
        res.scaled = SAT_NEG;
        res.status = ST_SATURATED;
      end else begin
        res.scaled = (num < 0) ? -quo[31:0] : quo[31:0];
      end
    end
    return res;
  endfunction

  // mostly values around the fitted range, so transforms land in and
  // just outside [0, 1]; some full-scale and edge values
  function automatic logic [DATA_W-1:0] sample_value(input logic [FEAT_W-1:0] feat);
    longint    span;
    longint    pick;
    bit [63:0] r64;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom;
    if (roll < 20) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return fitted[feat] ? lo_store[feat] : 32'h0;
        default: return fitted[feat] ? hi_store[feat] : 32'h0;
      endcase
    end
    if (!fitted[feat]) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    span = longint'(hi_store[feat]) - longint'(lo_store[feat]);
    r64  = {$urandom, $urandom};
    pick = longint'(lo_store[feat]) - span / 4 + longint'(r64 % (span + span / 2 + 1));
    if (pick > 64'sh7FFF_FFFF) pick = 64'sh7FFF_FFFF;
    if (pick < -64'sh8000_0000) pick = -64'sh8000_0000;
    return pick[31:0];
  endfunction

  task automatic push_sample(input logic mode, input logic first,
                             input logic [FEAT_W-1:0] feat, input logic [DATA_W-1:0] val,
                             input logic typed, input logic [DATA_W-1:0] exp_scaled,
                             input status_t exp_status);
    scaler_result_t due;
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_first_row <= first;
    in_feature   <= feat;
    in_value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = scale_sample(mode, first, feat, val);
    if (typed) begin
      due.scaled = exp_scaled;
      due.status = exp_status;
    end
    results_due.push_back(due);
    @(negedge clk);
  endtask

  task automatic write_register(input logic reg_sel, input logic [31:0] data);
    logic [31:0] want;
    want = (reg_sel == REG_NUM_FEATURES) ? {25'd0, data[NF_W-1:0]} : data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_NUM_FEATURES) nf_cfg = data[NF_W-1:0];
    else floor_cfg = data;
    @(negedge clk);
    // register reads back what was written
    if (prdata !== want) begin
      if (mismatch_count + cfg_mismatch_count < REPORT_LIMIT)
        $display("%0t: register readback: got %h, want %h", $realtime, prdata, want);
      cfg_mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // hold the sender off until every transaction has come back, then write both registers
  task automatic apply_setting(input logic [NF_W-1:0] nf, input logic [31:0] floor);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_register(REG_NUM_FEATURES, {25'd0, nf});
    write_register(REG_MIN_RANGE, floor);
  endtask

  // bursty result stall, roughly 7 per cent of cycles
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      out_stall <= ($urandom_range(99) < 50);
    end else begin
      out_stall <= ($urandom_range(99) < 4);
    end
  end

  always @(posedge clk) begin
    scaler_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        if (mismatch_count + cfg_mismatch_count < REPORT_LIMIT)
          $display("%0t: unexpected result: scaled %h status %0d feature %0d",
                   $realtime, out_scaled, out_status, out_feature_echo);
        mismatch_count++;
      end else begin
        due = results_due.pop_front();
        if (out_scaled !== due.scaled || out_status !== due.status ||
            out_feature_echo !== due.feat) begin
          if (mismatch_count + cfg_mismatch_count < REPORT_LIMIT)
            $display("%0t: mismatch: got scaled %h status %0d feature %0d, want %h %0d %0d",
                     $realtime, out_scaled, out_status, out_feature_echo,
                     due.scaled, due.status, due.feat);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [NF_W-1:0]   nf;
    logic [31:0]       floor;
    logic              mode;
    logic              first;
    logic [FEAT_W-1:0] feat;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_FIT;
    in_first_row   = 1'b0;
    in_feature     = '0;
    in_value       = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    nf_cfg         = 7'd64;
    floor_cfg      = 32'd1;
    quiet          = 1'b0;
    for (int f = 0; f < FEATURES; f++) begin
      fitted[f]   = 1'b0;
      lo_store[f] = '0;
      hi_store[f] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < PROBES; r++) begin
      if (probes[r].nf != nf_cfg || probes[r].floor != floor_cfg)
        apply_setting(probes[r].nf, probes[r].floor);
      push_sample(probes[r].mode, probes[r].first, probes[r].feat, probes[r].value,
                  probes[r].typed, probes[r].scaled, probes[r].status);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin nf = 7'd64; floor = 32'd1; end
        1: begin nf = 7'd1; floor = 32'd0; end
        2: begin nf = 7'd64; floor = 32'hFFFF_FFFF; end
        3: begin nf = 7'($urandom_range(1, 64)); floor = $urandom_range(0, 32'h0004_0000); end
        4: begin nf = 7'd64; floor = $urandom; end
        5: begin nf = 7'($urandom_range(1, 64)); floor = 32'd0; end
        6: begin nf = 7'd2; floor = 32'd1; end
        default: begin nf = 7'd64; floor = $urandom_range(0, 255); end
      endcase
      apply_setting(nf, floor);
      quiet = (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        feat  = ($urandom_range(99) < 90) ? FEAT_W'($urandom_range(0, nf_cfg - 1))
                                          : FEAT_W'($urandom_range(0, FEATURES - 1));
        mode  = ($urandom_range(99) < 35) ? MODE_FIT : MODE_TRANSFORM;
        first = (mode == MODE_FIT) ? ($urandom_range(99) < 12) : 1'($urandom);
        push_sample(mode, first, feat, sample_value(feat), 1'b0, '0, ST_OK);
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && cfg_mismatch_count == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mmfs_pkg.sv
sv/min_max_feature_scaler.sv
sv/mmfs_checker.sv
test/min_max_feature_scaler_tb.sv
